// ===== design/segment_plane_intersection_assert.svh =====
// assertion macros for the segment plane intersection block
`ifndef SEGMENT_PLANE_INTERSECTION_ASSERT_SVH
`define SEGMENT_PLANE_INTERSECTION_ASSERT_SVH
// implication checked every clock outside reset
`define SPI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spi assertion failed");
// condition that holds at every clock outside reset
`define SPI_ASSERT_ALW(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("spi assertion failed");
`endif

// ===== design/spi_pkg.sv =====
// shared constants, types and codes for the segment plane intersection block
package spi_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CRD_W = 32;
    localparam int DIST_W = 67;
    localparam int MAG_W = 67;
    localparam int NUM_REGS = 6;
    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_PLANE = 3'd1,
        KIND_START = 3'd2,
        KIND_END   = 3'd3,
        KIND_CROSS = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        REG_OX = 3'd0, REG_OY = 3'd1, REG_OZ = 3'd2,
        REG_NX = 3'd3, REG_NY = 3'd4, REG_NZ = 3'd5
    } t_reg;

    typedef logic signed [CRD_W-1:0] t_crd;
    typedef t_crd t_vec [3];
endpackage

// ===== design/segment_plane_intersection.sv =====
// Segment / plane intersection. Fully pipelined: one segment may be started
// every clock (busy is always low) and each gives exactly one result strobe
// after three distance stages, one classify stage, one divider stage per
// fraction bit, and two stages of interpolation. Results cannot be stalled.
// Registers at byte addresses 4*i.
module segment_plane_intersection #(
    parameter int FRAC_BITS = spi_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spi_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [31:0]          i_start_x,
    input  logic signed [31:0]          i_start_y,
    input  logic signed [31:0]          i_start_z,
    input  logic signed [31:0]          i_end_x,
    input  logic signed [31:0]          i_end_y,
    input  logic signed [31:0]          i_end_z,
    output logic                        o_valid,
    output logic [2:0]                  o_cut_kind,
    output logic [FRAC_BITS:0]          o_fraction,
    output logic signed [31:0]          o_cut_x,
    output logic signed [31:0]          o_cut_y,
    output logic signed [31:0]          o_cut_z
);
    import spi_pkg::*;

    localparam int LAT = FRAC_BITS + 4;

    t_crd r_cfg [NUM_REGS];
    t_vec w_p0, w_p1, w_org, w_nrm;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_idx  = paddr[ADDR_W-1:2];

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= (i == int'(REG_NZ)) ? 32'sd65536 : '0;
            end
        end else if (psel && penable && pwrite && w_idx < 3'(NUM_REGS)) begin
            r_cfg[w_idx] <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (w_idx < 3'(NUM_REGS)) prdata = r_cfg[w_idx];
    end

    always_comb begin
        w_p0[0] = i_start_x; w_p0[1] = i_start_y; w_p0[2] = i_start_z;
        w_p1[0] = i_end_x;   w_p1[1] = i_end_y;   w_p1[2] = i_end_z;
        for (int i = 0; i < 3; i++) begin
            w_org[i] = r_cfg[i];
            w_nrm[i] = r_cfg[3+i];
        end
    end

    // endpoint delay line alongside the arithmetic
    t_vec r_dp0 [LAT];
    t_vec r_dp1 [LAT];
    always_ff @(posedge i_clk) begin
        r_dp0[0] <= w_p0; r_dp1[0] <= w_p1;
        for (int s = 1; s < LAT; s++) begin
            r_dp0[s] <= r_dp0[s-1]; r_dp1[s] <= r_dp1[s-1];
        end
    end

    logic d_vld;
    logic signed [DIST_W-1:0] d0, d1;
    spi_dist u_dist (.i_clk, .i_rst_n, .i_vld(start), .i_p0(w_p0), .i_p1(w_p1),
        .i_org(w_org), .i_nrm(w_nrm), .o_vld(d_vld), .o_d0(d0), .o_d1(d1));

    // classify and take magnitudes
    logic                 r_cv;
    t_kind                r_ck;
    logic [MAG_W-1:0]     r_num;
    logic [MAG_W:0]       r_den;
    logic z0, z1, n0, n1;
    logic [MAG_W-1:0] m0, m1;
    t_kind w_kind;
    assign z0 = (d0 == '0);
    assign z1 = (d1 == '0);
    assign n0 = d0[DIST_W-1];
    assign n1 = d1[DIST_W-1];
    assign m0 = n0 ? MAG_W'(-d0) : MAG_W'(d0);
    assign m1 = n1 ? MAG_W'(-d1) : MAG_W'(d1);
    always_comb begin
        priority if (z0 && z1)       w_kind = KIND_PLANE;
        else if (z0)                 w_kind = KIND_START;
        else if (z1)                 w_kind = KIND_END;
        else if (n0 == n1)           w_kind = KIND_NONE;
        else                         w_kind = KIND_CROSS;
    end
    always_ff @(posedge i_clk) begin
        r_ck  <= w_kind;
        r_num <= m0;
        r_den <= {1'b0, m0} + {1'b0, m1};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cv <= 1'b0;
        else          r_cv <= d_vld;
    end

    logic q_vld;
    logic [FRAC_BITS-1:0] quo;
    spi_div #(.FRAC_BITS(FRAC_BITS)) u_div (.i_clk, .i_rst_n, .i_vld(r_cv),
        .i_num(r_num), .i_den(r_den), .o_vld(q_vld), .o_quo(quo));

    // kind delay through the divider
    t_kind r_kd [FRAC_BITS];
    always_ff @(posedge i_clk) begin
        r_kd[0] <= r_ck;
        for (int s = 1; s < FRAC_BITS; s++) r_kd[s] <= r_kd[s-1];
    end

    logic [FRAC_BITS:0] w_frac;
    always_comb begin
        unique case (r_kd[FRAC_BITS-1])
            KIND_END:   w_frac = {1'b1, {FRAC_BITS{1'b0}}};
            KIND_CROSS: w_frac = {1'b0, quo};
            default:    w_frac = '0;
        endcase
    end

    t_vec cut;
    spi_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (.i_clk, .i_rst_n, .i_vld(q_vld),
        .i_kind(r_kd[FRAC_BITS-1]), .i_frac(w_frac), .i_p0(r_dp0[LAT-1]),
        .i_p1(r_dp1[LAT-1]), .o_vld(o_valid), .o_kind(o_cut_kind),
        .o_frac(o_fraction), .o_cut(cut));

    assign o_cut_x = cut[0];
    assign o_cut_y = cut[1];
    assign o_cut_z = cut[2];
endmodule

// ===== design/spi_dist.sv =====
// signed plane distances of both endpoints, three register stages
module spi_dist (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vld,
    input  spi_pkg::t_vec                   i_p0,
    input  spi_pkg::t_vec                   i_p1,
    input  spi_pkg::t_vec                   i_org,
    input  spi_pkg::t_vec                   i_nrm,
    output logic                            o_vld,
    output logic signed [spi_pkg::DIST_W-1:0] o_d0,
    output logic signed [spi_pkg::DIST_W-1:0] o_d1
);
    import spi_pkg::*;

    logic                       r_v1, r_v2;
    logic signed [CRD_W:0]      r_a0 [3];
    logic signed [CRD_W:0]      r_a1 [3];
    t_crd                       r_n [3];
    logic signed [64:0]         r_m0 [3];
    logic signed [64:0]         r_m1 [3];

    // stage one: differences to origin
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_a0[i] <= {i_p0[i][CRD_W-1], i_p0[i]} - {i_org[i][CRD_W-1], i_org[i]};
            r_a1[i] <= {i_p1[i][CRD_W-1], i_p1[i]} - {i_org[i][CRD_W-1], i_org[i]};
            r_n[i]  <= i_nrm[i];
        end
    end

    // stage two: products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_m0[i] <= 65'(r_a0[i] * r_n[i]);
            r_m1[i] <= 65'(r_a1[i] * r_n[i]);
        end
    end

    // stage three: sums
    always_ff @(posedge i_clk) begin
        o_d0 <= DIST_W'(r_m0[0]) + DIST_W'(r_m0[1]) + DIST_W'(r_m0[2]);
        o_d1 <= DIST_W'(r_m1[0]) + DIST_W'(r_m1[1]) + DIST_W'(r_m1[2]);
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; o_vld <= 1'b0;
        end else begin
            r_v1 <= i_vld; r_v2 <= r_v1; o_vld <= r_v2;
        end
    end
endmodule

// ===== design/spi_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module spi_div #(
    parameter int FRAC_BITS = spi_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [spi_pkg::MAG_W-1:0]     i_num,
    input  logic [spi_pkg::MAG_W:0]       i_den,
    output logic                          o_vld,
    output logic [FRAC_BITS-1:0]          o_quo
);
    import spi_pkg::*;

    localparam int RW = MAG_W + 2;

    logic [RW-1:0]        r_rem [FRAC_BITS+1];
    logic [MAG_W:0]       r_den [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] r_q   [FRAC_BITS+1];
    logic                 r_v   [FRAC_BITS+1];

    always_comb begin
        r_rem[0] = RW'(i_num);
        r_den[0] = i_den;
        r_q[0]   = '0;
        r_v[0]   = i_vld;
    end

    // one shift and subtract per stage
    for (genvar s = 0; s < FRAC_BITS; s++) begin : g_st
        logic [RW-1:0] w_sh;
        assign w_sh = {r_rem[s][RW-2:0], 1'b0};
        always_ff @(posedge i_clk) begin
            if (w_sh >= RW'(r_den[s])) begin
                r_rem[s+1] <= w_sh - RW'(r_den[s]);
                r_q[s+1]   <= {r_q[s][FRAC_BITS-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= w_sh;
                r_q[s+1]   <= {r_q[s][FRAC_BITS-2:0], 1'b0};
            end
            r_den[s+1] <= r_den[s];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
        end
    end

    assign o_vld = r_v[FRAC_BITS];
    assign o_quo = r_q[FRAC_BITS];
endmodule

// ===== design/spi_lerp.sv =====
// interpolated point, product stage then floor shift and add
module spi_lerp #(
    parameter int FRAC_BITS = spi_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [2:0]           i_kind,
    input  logic [FRAC_BITS:0]   i_frac,
    input  spi_pkg::t_vec        i_p0,
    input  spi_pkg::t_vec        i_p1,
    output logic                 o_vld,
    output logic [2:0]           o_kind,
    output logic [FRAC_BITS:0]   o_frac,
    output spi_pkg::t_vec        o_cut
);
    import spi_pkg::*;

    localparam int PW = CRD_W + FRAC_BITS + 3;

    logic                   r_v;
    logic [2:0]             r_kind;
    logic [FRAC_BITS:0]     r_frac;
    t_crd                   r_p0 [3];
    logic signed [PW-1:0]   r_prod [3];

    // product of difference and fraction
    always_ff @(posedge i_clk) begin
        r_kind <= i_kind;
        r_frac <= i_frac;
        for (int i = 0; i < 3; i++) begin
            r_p0[i]   <= i_p0[i];
            r_prod[i] <= PW'(($signed({i_p1[i][CRD_W-1], i_p1[i]})
                         - $signed({i_p0[i][CRD_W-1], i_p0[i]}))
                         * $signed({1'b0, i_frac}));
        end
    end

    // arithmetic shift floors; zero fields for none and in plane
    always_ff @(posedge i_clk) begin
        o_kind <= r_kind;
        for (int i = 0; i < 3; i++) begin
            if (r_kind == KIND_NONE || r_kind == KIND_PLANE) begin
                o_cut[i] <= '0;
            end else begin
                o_cut[i] <= r_p0[i] + CRD_W'(r_prod[i] >>> FRAC_BITS);
            end
        end
        o_frac <= (r_kind == KIND_NONE || r_kind == KIND_PLANE) ? '0 : r_frac;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0; o_vld <= 1'b0;
        end else begin
            r_v <= i_vld; o_vld <= r_v;
        end
    end
endmodule

// ===== design/spi_checker.sv =====
// port level checks for the segment plane intersection block
`include "segment_plane_intersection_assert.svh"
module spi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_valid,
    input logic [2:0]  o_cut_kind,
    input logic [16:0] o_fraction
);
    import spi_pkg::*;
    `SPI_ASSERT_ALW(a_never_busy, !busy)
    `SPI_ASSERT_IMP(a_kind_legal, o_valid, o_cut_kind <= KIND_CROSS)
    `SPI_ASSERT_IMP(a_start_zero, o_valid && o_cut_kind == KIND_START, o_fraction == '0)
    `SPI_ASSERT_IMP(a_end_one, o_valid && o_cut_kind == KIND_END, o_fraction == 17'h10000)
endmodule

bind segment_plane_intersection spi_checker u_chk (.i_clk, .i_rst_n, .busy, .o_valid,
    .o_cut_kind, .o_fraction);
